[rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and transfer types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int NUM_BLOCKS  = 16;
    localparam int BLOCK_BYTES = 1024;
    localparam int MAX_BYTES   = NUM_BLOCKS * BLOCK_BYTES;

    localparam int BYTES_W = 20;
    localparam int HEAD_W  = 5;
    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int PTR_W   = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int ACC_W   = $clog2(MAX_BYTES + 1);
    localparam int CMP_W   = (ACC_W > BYTES_W) ? ACC_W : BYTES_W;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [2:0] TAG_FREE   = 3'd0;
    localparam logic [2:0] TAG_SINGLE = 3'd1;
    localparam logic [2:0] TAG_FIRST  = 3'd2;
    localparam logic [2:0] TAG_CONT   = 3'd3;
    localparam logic [2:0] TAG_LAST   = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ZERO      = 3'd1;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
    localparam logic [2:0] ERR_NO_RUN    = 3'd3;
    localparam logic [2:0] ERR_BAD_FREE  = 3'd4;

    typedef struct packed {
        logic               func;
        logic [BYTES_W-1:0] request_bytes;
        logic [HEAD_W-1:0]  head_index;
    } t_in;

    typedef struct packed {
        logic       ok;
        logic [3:0] block_index;
        logic [4:0] block_count;
        logic [2:0] error_code;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       scan_init;
        logic       scan_step;
        logic       wr_step;
        logic       free_step;
        logic       set_err;
        logic [2:0] err_code;
        logic       res_load;
    } t_cmd;

    typedef struct packed {
        logic       zero;
        logic       too_large;
        logic       div_done;
        logic [2:0] tag_cur;
        logic       scan_hit;
        logic       ptr_last;
        logic       ptr_end;
        logic       wr_last;
        logic       head_oob;
        logic       out_free;
    } t_stat;

endpackage

[rtl/ffba_dpath.sv]
// ----------------------------------------------------------------------------
// ffba_dpath
// Tag store, size conversion, run search, chain walk and result register.
// ----------------------------------------------------------------------------
module ffba_dpath
    import ffba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_out  o_out
);

    logic [2:0]         r_tags [NUM_BLOCKS];
    logic               r_func;
    logic [BYTES_W-1:0] r_bytes;
    logic [HEAD_W-1:0]  r_head;
    logic [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_run;
    logic [CNT_W-1:0]   r_left;
    logic [CNT_W-1:0]   r_freed;
    logic [PTR_W-1:0]   r_ptr;
    logic [IDX_W-1:0]   r_start;
    logic [2:0]         r_err;
    logic               r_valid;
    logic               n_valid;
    t_out               r_out;
    t_out               n_out;

    logic [IDX_W-1:0] idx;
    logic [2:0]       tag_cur;
    logic [2:0]       wr_tag;
    logic [IDX_W-1:0] cur_start;
    logic [CNT_W-1:0] run_inc;
    logic             ok;

    assign idx       = r_ptr[IDX_W-1:0];
    assign tag_cur   = r_tags[idx];
    assign cur_start = (r_run == '0) ? idx : r_start;
    assign run_inc   = r_run + CNT_W'(1);

    always_comb begin
        if (r_count == CNT_W'(1)) begin
            wr_tag = TAG_SINGLE;
        end else if (idx == r_start) begin
            wr_tag = TAG_FIRST;
        end else if (r_left == CNT_W'(1)) begin
            wr_tag = TAG_LAST;
        end else begin
            wr_tag = TAG_CONT;
        end
    end

    always_comb begin
        o_stat.zero      = (r_bytes == '0);
        o_stat.too_large = (CMP_W'(r_bytes) > CMP_W'(MAX_BYTES));
        o_stat.div_done  = (CMP_W'(r_acc) >= CMP_W'(r_bytes));
        o_stat.tag_cur   = tag_cur;
        o_stat.scan_hit  = (tag_cur == TAG_FREE) && (run_inc == r_count);
        o_stat.ptr_last  = (r_ptr == PTR_W'(NUM_BLOCKS - 1));
        o_stat.ptr_end   = (r_ptr == PTR_W'(NUM_BLOCKS));
        o_stat.wr_last   = (r_left == CNT_W'(1));
        o_stat.head_oob  = (int'(r_head) >= NUM_BLOCKS);
        o_stat.out_free  = !r_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BLOCKS; k++) begin
                r_tags[k] <= TAG_FREE;
            end
        end else if (i_cmd.wr_step) begin
            r_tags[idx] <= wr_tag;
        end else if (i_cmd.free_step) begin
            r_tags[idx] <= TAG_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_in.func;
            r_bytes <= i_in.request_bytes;
            r_head  <= i_in.head_index;
            r_acc   <= '0;
            r_count <= '0;
            r_freed <= '0;
            r_ptr   <= PTR_W'(i_in.head_index);
        end
        if (i_cmd.div_step) begin
            r_acc   <= r_acc + ACC_W'(BLOCK_BYTES);
            r_count <= r_count + CNT_W'(1);
        end
        if (i_cmd.scan_init) begin
            r_ptr <= '0;
            r_run <= '0;
        end
        if (i_cmd.scan_step) begin
            if (o_stat.scan_hit) begin
                r_start <= cur_start;
                r_ptr   <= PTR_W'(cur_start);
                r_left  <= r_count;
            end else if (tag_cur == TAG_FREE) begin
                r_start <= cur_start;
                r_run   <= run_inc;
                r_ptr   <= r_ptr + PTR_W'(1);
            end else begin
                r_run <= '0;
                r_ptr <= r_ptr + PTR_W'(1);
            end
        end
        if (i_cmd.wr_step) begin
            r_ptr  <= r_ptr + PTR_W'(1);
            r_left <= r_left - CNT_W'(1);
        end
        if (i_cmd.free_step) begin
            r_ptr   <= r_ptr + PTR_W'(1);
            r_freed <= r_freed + CNT_W'(1);
        end
        if (i_cmd.set_err) begin
            r_err <= i_cmd.err_code;
        end
    end

    assign ok = (r_err == ERR_NONE);

    always_comb begin
        n_out.ok          = ok;
        n_out.error_code  = r_err;
        n_out.block_index = '0;
        n_out.block_count = '0;
        if (ok) begin
            if (r_func == FUNC_ALLOC) begin
                n_out.block_index = 4'(r_start);
                n_out.block_count = 5'(r_count);
            end else begin
                n_out.block_index = 4'(r_head);
                n_out.block_count = 5'(r_freed);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.res_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

[rtl/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer of the allocator: size conversion, run search, tagging and free.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_func,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_FCHK  = 3'd4;
    localparam logic [2:0] S_FWALK = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_FREE) ? S_FCHK : S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.zero) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ERR_ZERO;
                    n_state        = S_DONE;
                end else if (i_stat.too_large) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ERR_TOO_LARGE;
                    n_state        = S_DONE;
                end else if (i_stat.div_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_WRITE;
                end else if (i_stat.ptr_last) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ERR_NO_RUN;
                    n_state        = S_DONE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_step = 1'b1;
                if (i_stat.wr_last) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ERR_NONE;
                    n_state        = S_DONE;
                end
            end
            S_FCHK: begin
                o_cmd.set_err = 1'b1;
                if (i_stat.head_oob) begin
                    o_cmd.err_code = ERR_BAD_FREE;
                    n_state        = S_DONE;
                end else if (i_stat.tag_cur == TAG_SINGLE) begin
                    o_cmd.free_step = 1'b1;
                    o_cmd.err_code  = ERR_NONE;
                    n_state         = S_DONE;
                end else if (i_stat.tag_cur == TAG_FIRST) begin
                    o_cmd.free_step = 1'b1;
                    o_cmd.err_code  = ERR_NONE;
                    n_state         = S_FWALK;
                end else begin
                    o_cmd.err_code = ERR_BAD_FREE;
                    n_state        = S_DONE;
                end
            end
            S_FWALK: begin
                if (i_stat.ptr_end) begin
                    n_state = S_DONE;
                end else if (i_stat.tag_cur == TAG_CONT) begin
                    o_cmd.free_step = 1'b1;
                end else if (i_stat.tag_cur == TAG_LAST) begin
                    o_cmd.free_step = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/first_fit_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator of contiguous runs over a small heap of tagged blocks.
//
// Requests arrive on the input channel (i_in_valid, o_in_ready, i_in) and
// each one yields exactly one transfer on the result channel (o_out_valid,
// i_out_ready, o_out). An allocate converts its byte size to a block count
// by repeated addition of the block size, one step per cycle, then scans the
// tag store one block per cycle for the lowest free run and tags the run one
// block per cycle. A free checks the head and clears the chain one block per
// cycle. One request is in work at a time; the next one is taken as soon as
// the previous result sits in the output register, even while it waits there.
// Reset clears every tag to free at once and empties the output register.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register is free.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
    import ffba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_cmd  cmd;
    t_stat stat;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ffba_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[rtl/ffba_checker.sv]
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before its transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.ok |-> o_out.error_code == ERR_NONE)
        else $error("successful result carries an error code");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.ok |-> o_out.block_index == '0 &&
            o_out.block_count == '0 && o_out.error_code != ERR_NONE)
        else $error("failed result has stray fields");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after a request transfer");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);
